### sv/srhm_pkg.sv
// ----------------------------------------------------------------------------
// srhm_pkg
// Shared types and constants of the sensor range health monitor.
// ----------------------------------------------------------------------------
package srhm_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// configuration register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOWER_LIMIT  = 8'd0,
		REG_UPPER_LIMIT  = 8'd1,
		REG_FILTER_YEAR  = 8'd2,
		REG_FILTER_MONTH = 8'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_RECORD = 1'b0,
		REQ_QUERY  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		HEALTH_GOOD        = 2'd0,
		HEALTH_PROBLEMATIC = 2'd1,
		HEALTH_DEFECTIVE   = 2'd2
	} health_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // capture the item and read its table entry
		logic finish;   // update the entry, flags and result register
	} srhm_cmd_t;

endpackage

### sv/sensor_range_health_monitor.sv
// ----------------------------------------------------------------------------
// sensor_range_health_monitor
// Per-sensor saturating reading/fault counters with range check, date filter
// match, highest index tracking and health status query.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  in      | in_valid / in_stall              | record or query
//  out     | out_valid / out_stall            | status, counts, flags
//  cfg     | cfg_we, cfg_index, cfg_data      | register write
//
//  An item goes through a table read (registered), then update and write.
//  The single-port counter table sets that order; one item is in work.
//  The next item is taken while a result still waits in the output register.
//  Reset clears all counters at once through per-entry valid flops.
//  A full, stalled output register holds the item in its update step.
// ----------------------------------------------------------------------------
module sensor_range_health_monitor
	import srhm_pkg::*;
#(
	parameter int NUM_SENSORS = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   req_type,
	input  logic [7:0]             sensor_index,
	input  logic signed [15:0]     sample_value,
	input  logic [15:0]            record_year,
	input  logic [7:0]             record_month,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             health_status,
	output logic [15:0]            reading_count,
	output logic [15:0]            fault_count,
	output logic                   date_match,
	output logic                   any_match,
	output logic [7:0]             highest_index,
	output logic                   highest_valid
);

	srhm_cmd_t cmd;

	srhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	srhm_dp #(
		.NUM_SENSORS (NUM_SENSORS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.sensor_index  (sensor_index),
		.sample_value  (sample_value),
		.record_year   (record_year),
		.record_month  (record_month),
		.health_status (health_status),
		.reading_count (reading_count),
		.fault_count   (fault_count),
		.date_match    (date_match),
		.any_match     (any_match),
		.highest_index (highest_index),
		.highest_valid (highest_valid)
	);

endmodule

### sv/srhm_ctrl.sv
// ----------------------------------------------------------------------------
// srhm_ctrl
// Sequencer: one item at a time, table read then update, output handshake.
// ----------------------------------------------------------------------------
module srhm_ctrl
	import srhm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output srhm_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.accept = (state_q == ST_IDLE) && in_valid;
	// result register must be empty or drained this cycle
	assign cmd.finish = (state_q == ST_CALC) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (cmd.finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished item did not raise out_valid");

	a_accept_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> in_stall && !cmd.accept)
		else $error("new item taken while one is at work");

	a_blocked_item_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) && out_valid_q && out_stall |=> state_q == ST_CALC)
		else $error("item finished while result register was full");

	a_finish_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !in_stall)
		else $error("input not released after finish");

endmodule

### sv/srhm_dp.sv
// ----------------------------------------------------------------------------
// srhm_dp
// Datapath: limit/filter registers, counter table, flags and result register.
// ----------------------------------------------------------------------------
module srhm_dp
	import srhm_pkg::*;
#(
	parameter int NUM_SENSORS = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srhm_cmd_t              cmd,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   req_type,
	input  logic [7:0]             sensor_index,
	input  logic signed [15:0]     sample_value,
	input  logic [15:0]            record_year,
	input  logic [7:0]             record_month,
	output logic [1:0]             health_status,
	output logic [15:0]            reading_count,
	output logic [15:0]            fault_count,
	output logic                   date_match,
	output logic                   any_match,
	output logic [7:0]             highest_index,
	output logic                   highest_valid
);

	localparam int CW     = COUNT_WIDTH;
	localparam int ADDR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	function automatic logic [15:0] clamp16(input logic [CW-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	// configuration
	logic signed [15:0] lower_q, upper_q;
	logic [15:0]        fyear_q;
	logic [7:0]         fmonth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= -16'sd1000;
			upper_q  <= 16'sd1000;
			fyear_q  <= '0;
			fmonth_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWER_LIMIT:  lower_q  <= cfg_data;
				REG_UPPER_LIMIT:  upper_q  <= cfg_data;
				REG_FILTER_YEAR:  fyear_q  <= cfg_data;
				REG_FILTER_MONTH: fmonth_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic               req_s1;
	logic [7:0]         idx_s1;
	logic signed [15:0] sample_s1;
	logic [15:0]        year_s1;
	logic [7:0]         month_s1;
	logic               in_table_s1;
	logic               in_table;
	logic [ADDR_W-1:0]  addr, addr_s1;

	assign in_table = ({1'b0, sensor_index} < 9'(NUM_SENSORS));
	assign addr     = sensor_index[ADDR_W-1:0];
	assign addr_s1  = idx_s1[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_s1      <= req_type;
			idx_s1      <= sensor_index;
			sample_s1   <= sample_value;
			year_s1     <= record_year;
			month_s1    <= record_month;
			in_table_s1 <= in_table;
		end
	end

	// update terms
	logic          is_rec, fault;
	logic [CW-1:0] r_cur, f_cur, r_new, f_new;

	// counter table: {faults, readings}; entries without a valid bit read as zero
	logic [2*CW-1:0]        mem [NUM_SENSORS];
	logic [2*CW-1:0]        rd_q;
	logic [NUM_SENSORS-1:0] vld_q;
	logic                   rd_vld_q;
	logic                   do_write;

	always_ff @(posedge clk) begin
		if (cmd.accept) rd_q <= mem[addr];
		if (do_write)   mem[addr_s1] <= {f_new, r_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.accept) rd_vld_q <= in_table && vld_q[addr];
			if (do_write)   vld_q[addr_s1] <= 1'b1;
		end
	end

	// update
	assign is_rec   = (req_s1 == REQ_RECORD);
	assign do_write = cmd.finish && is_rec && in_table_s1;
	assign fault    = (sample_s1 < lower_q) || (sample_s1 > upper_q);
	assign r_cur    = (rd_vld_q && in_table_s1) ? rd_q[CW-1:0]      : '0;
	assign f_cur    = (rd_vld_q && in_table_s1) ? rd_q[2*CW-1:CW]  : '0;

	always_comb begin
		r_new = r_cur;
		f_new = f_cur;
		if (is_rec && in_table_s1) begin
			if (r_cur != CNT_MAX) r_new = r_cur + 1'b1;
			if (fault && f_cur != CNT_MAX) f_new = f_cur + 1'b1;
		end
	end

	// sticky flags
	logic       match_q, seen_q;
	logic [7:0] max_q;
	logic       dmatch, match_nx, seen_nx;
	logic [7:0] max_nx;
	logic [1:0] status;

	assign dmatch   = is_rec && (year_s1 == fyear_q) && (month_s1 == fmonth_q);
	assign match_nx = match_q || dmatch;
	assign seen_nx  = seen_q || is_rec;
	assign max_nx   = (is_rec && (!seen_q || idx_s1 > max_q)) ? idx_s1 : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			seen_q  <= 1'b0;
			max_q   <= '0;
		end else if (cmd.finish) begin
			match_q <= match_nx;
			seen_q  <= seen_nx;
			max_q   <= max_nx;
		end
	end

	always_comb begin
		priority if (f_new == '0) status = HEALTH_GOOD;
		else if (f_new < r_new)   status = HEALTH_PROBLEMATIC;
		else                      status = HEALTH_DEFECTIVE;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			health_status <= status;
			reading_count <= clamp16(r_new);
			fault_count   <= clamp16(f_new);
			date_match    <= dmatch;
			any_match     <= match_nx;
			highest_index <= max_nx;
			highest_valid <= seen_nx;
		end
	end

	a_query_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !is_rec |=> $stable(max_q) && $stable(match_q) && $stable(seen_q))
		else $error("query changed record flags");

	a_no_write_outside: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> in_table_s1 && is_rec)
		else $error("table write for query or index beyond table");

	a_faults_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> f_new <= r_new || !rd_vld_q)
		else $error("fault count above reading count");

endmodule
